### rtl/plsu_pkg.sv
// ----------------------------------------------------------------------------
// plsu_pkg
// Shared types and constants of the positional list store unit.
// ----------------------------------------------------------------------------
package plsu_pkg;

  localparam int unsigned DEF_CAPACITY    = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 32;
  localparam int unsigned IO_VALUE_WIDTH  = 32;
  localparam int unsigned POS_WIDTH       = 7;
  localparam int unsigned TREE_FANIN      = 8;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_RETRIEVE = 3'd2,
    ACT_REPLACE  = 3'd3,
    ACT_SWAP     = 3'd4,
    ACT_CLEAR    = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BAD_POS = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_WRITE  = 3'd3,
    OP_SWAP   = 3'd4
  } cell_op_t;

endpackage

### rtl/plsu_cell.sv
// ----------------------------------------------------------------------------
// plsu_cell
// One list slot: shifts with its neighbours, takes writes and swaps, and
// offers its value on the read lines when addressed.
// ----------------------------------------------------------------------------
module plsu_cell import plsu_pkg::*; #(
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH,
  parameter int unsigned IDX         = 0
) (
  input  logic                   clk,
  input  cell_op_t               op,
  input  logic [IDX_W-1:0]       pos_a,
  input  logic [IDX_W-1:0]       pos_b,
  input  logic [VALUE_WIDTH-1:0] wr_value,
  input  logic [VALUE_WIDTH-1:0] val_a,
  input  logic [VALUE_WIDTH-1:0] val_b,
  input  logic [VALUE_WIDTH-1:0] lower,
  input  logic [VALUE_WIDTH-1:0] upper,
  output logic [VALUE_WIDTH-1:0] slot,
  output logic [VALUE_WIDTH-1:0] rd_a,
  output logic [VALUE_WIDTH-1:0] rd_b
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                   hit_a;
  logic                   hit_b;
  logic [VALUE_WIDTH-1:0] slot_next;

  assign hit_a = (pos_a == MY_IDX);
  assign hit_b = (pos_b == MY_IDX);
  assign rd_a  = hit_a ? slot : '0;
  assign rd_b  = hit_b ? slot : '0;

  always_comb begin
    slot_next = slot;
    unique case (op)
      OP_HOLD:   slot_next = slot;
      OP_INSERT: begin
        if (MY_IDX > pos_a) slot_next = lower;
        else if (hit_a)     slot_next = wr_value;
      end
      OP_DELETE: begin
        if (MY_IDX >= pos_a) slot_next = upper;
      end
      OP_WRITE: begin
        if (hit_a) slot_next = wr_value;
      end
      OP_SWAP: begin
        if (hit_a)      slot_next = val_b;
        else if (hit_b) slot_next = val_a;
      end
      default:   slot_next = slot;
    endcase
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

### rtl/plsu_read_tree.sv
// ----------------------------------------------------------------------------
// plsu_read_tree
// Two-stage registered OR tree that gathers the addressed slot values.
// ----------------------------------------------------------------------------
module plsu_read_tree import plsu_pkg::*; #(
  parameter int unsigned CAPACITY    = DEF_CAPACITY,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] rd_a [CAPACITY],
  input  logic [VALUE_WIDTH-1:0] rd_b [CAPACITY],
  output logic [VALUE_WIDTH-1:0] val_a,
  output logic [VALUE_WIDTH-1:0] val_b
);

  localparam int unsigned GROUPS = (CAPACITY + TREE_FANIN - 1) / TREE_FANIN;
  localparam int unsigned PADDED = GROUPS * TREE_FANIN;

  logic [VALUE_WIDTH-1:0] pad_a [PADDED];
  logic [VALUE_WIDTH-1:0] pad_b [PADDED];
  logic [VALUE_WIDTH-1:0] grp_a [GROUPS];
  logic [VALUE_WIDTH-1:0] grp_b [GROUPS];
  logic [VALUE_WIDTH-1:0] sum_a;
  logic [VALUE_WIDTH-1:0] sum_b;

  for (genvar i = 0; i < PADDED; i++) begin : g_pad
    if (i < CAPACITY) begin : g_used
      assign pad_a[i] = rd_a[i];
      assign pad_b[i] = rd_b[i];
    end else begin : g_zero
      assign pad_a[i] = '0;
      assign pad_b[i] = '0;
    end
  end

  for (genvar k = 0; k < GROUPS; k++) begin : g_grp
    logic [VALUE_WIDTH-1:0] acc_a;
    logic [VALUE_WIDTH-1:0] acc_b;

    always_comb begin
      acc_a = '0;
      acc_b = '0;
      for (int j = 0; j < TREE_FANIN; j++) begin
        acc_a = acc_a | pad_a[k*TREE_FANIN + j];
        acc_b = acc_b | pad_b[k*TREE_FANIN + j];
      end
    end

    always_ff @(posedge clk) begin
      grp_a[k] <= acc_a;
      grp_b[k] <= acc_b;
    end
  end

  always_comb begin
    sum_a = '0;
    sum_b = '0;
    for (int k = 0; k < GROUPS; k++) begin
      sum_a = sum_a | grp_a[k];
      sum_b = sum_b | grp_b[k];
    end
  end

  always_ff @(posedge clk) begin
    val_a <= sum_a;
    val_b <= sum_b;
  end

endmodule

### rtl/positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Fixed-capacity ordered list of signed values addressed by 1-based position.
// ----------------------------------------------------------------------------
// One command is taken at a time; the next is taken only after the result of
// the last one has been handed to the output register, which waits while an
// earlier result is still unread on out_ready. Each command passes through
// the two-stage registered read tree (states S_READ1, S_READ2) that gathers
// the addressed slots from the row of cells, then the apply state S_APPLY in
// which every cell shifts, writes or swaps in parallel, and then S_DONE,
// which hands the result to the output register. A command may be accepted
// while the previous result still waits on out_ready.
module positional_list_store_unit import plsu_pkg::*; #(
  parameter int unsigned CAPACITY    = DEF_CAPACITY,
  parameter int unsigned VALUE_WIDTH = DEF_VALUE_WIDTH,
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                action,
  input  logic [POS_WIDTH-1:0]      position,
  input  logic [POS_WIDTH-1:0]      second_position,
  input  logic [IO_VALUE_WIDTH-1:0] item_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [IO_VALUE_WIDTH-1:0] read_value,
  output logic [CNT_W-1:0]          item_count,
  output logic                      is_empty,
  output logic                      is_full
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W = ((CNT_W > POS_WIDTH) ? CNT_W : POS_WIDTH) + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ1,
    S_READ2,
    S_APPLY,
    S_DONE
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  act_t                      cmd_act;
  logic [POS_WIDTH-1:0]      cmd_pos;
  logic [POS_WIDTH-1:0]      cmd_pos2;
  logic [VALUE_WIDTH-1:0]    cmd_value;
  stat_t                     res_status;
  logic [IO_VALUE_WIDTH-1:0] res_rd;
  stat_t                     hold_status;
  logic [IO_VALUE_WIDTH-1:0] hold_rd;

  logic [CMP_W-1:0]          pos_w;
  logic [CMP_W-1:0]          pos2_w;
  logic [CMP_W-1:0]          cnt_w;
  logic                      pos_ok;
  logic                      pos2_ok;
  logic                      ins_ok;
  logic [IDX_W-1:0]          idx_a;
  logic [IDX_W-1:0]          idx_b;

  cell_op_t                  cell_op;
  logic [VALUE_WIDTH-1:0]    slot  [CAPACITY];
  logic [VALUE_WIDTH-1:0]    rd_a  [CAPACITY];
  logic [VALUE_WIDTH-1:0]    rd_b  [CAPACITY];
  logic [VALUE_WIDTH-1:0]    val_a;
  logic [VALUE_WIDTH-1:0]    val_b;

  assign in_ready = (state == S_IDLE);

  assign pos_w   = CMP_W'(cmd_pos);
  assign pos2_w  = CMP_W'(cmd_pos2);
  assign cnt_w   = CMP_W'(count);
  assign pos_ok  = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos2_ok = (pos2_w != '0) && (pos2_w <= cnt_w);
  assign ins_ok  = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
  assign idx_a   = IDX_W'(pos_w - CMP_W'(1));
  assign idx_b   = IDX_W'(pos2_w - CMP_W'(1));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lower;
    logic [VALUE_WIDTH-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = slot[i];
    end else begin : g_lower
      assign lower = slot[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper = slot[i];
    end else begin : g_upper
      assign upper = slot[i+1];
    end

    plsu_cell #(
      .IDX_W       (IDX_W),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk      (clk),
      .op       (cell_op),
      .pos_a    (idx_a),
      .pos_b    (idx_b),
      .wr_value (cmd_value),
      .val_a    (val_a),
      .val_b    (val_b),
      .lower    (lower),
      .upper    (upper),
      .slot     (slot[i]),
      .rd_a     (rd_a[i]),
      .rd_b     (rd_b[i])
    );
  end

  plsu_read_tree #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_read_tree (
    .clk   (clk),
    .rd_a  (rd_a),
    .rd_b  (rd_b),
    .val_a (val_a),
    .val_b (val_b)
  );

  always_comb begin
    cell_op    = OP_HOLD;
    res_status = ST_OK;
    res_rd     = '0;
    count_next = count;
    if (state == S_APPLY) begin
      unique case (cmd_act)
        ACT_INSERT: begin
          if (count == CNT_FULL) begin
            res_status = ST_FULL;
          end else if (!ins_ok) begin
            res_status = ST_BAD_POS;
          end else begin
            cell_op    = OP_INSERT;
            count_next = count + CNT_W'(1);
          end
        end
        ACT_DELETE, ACT_RETRIEVE, ACT_REPLACE: begin
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else if (!pos_ok) begin
            res_status = ST_BAD_POS;
          end else if (cmd_act == ACT_REPLACE) begin
            cell_op = OP_WRITE;
          end else begin
            res_rd = IO_VALUE_WIDTH'(signed'(val_a));
            if (cmd_act == ACT_DELETE) begin
              cell_op    = OP_DELETE;
              count_next = count - CNT_W'(1);
            end
          end
        end
        ACT_SWAP: begin
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else if (!pos_ok || !pos2_ok) begin
            res_status = ST_BAD_POS;
          end else begin
            cell_op = OP_SWAP;
          end
        end
        ACT_CLEAR: count_next = '0;
        default:   count_next = count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_act   <= act_t'(action);
            cmd_pos   <= position;
            cmd_pos2  <= second_position;
            cmd_value <= VALUE_WIDTH'(signed'(item_value));
            state     <= S_READ1;
          end
        end
        S_READ1: state <= S_READ2;
        S_READ2: state <= S_APPLY;
        S_APPLY: begin
          count       <= count_next;
          hold_status <= res_status;
          hold_rd     <= res_rd;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            status     <= hold_status;
            read_value <= hold_rd;
            item_count <= count;
            is_empty   <= (count == '0);
            is_full    <= (count == CNT_FULL);
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/plsu_checker.sv
// ----------------------------------------------------------------------------
// plsu_checker
// Port-level checks on the positional list store unit, bound to the top.
// ----------------------------------------------------------------------------
module plsu_checker import plsu_pkg::*; #(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                status,
  input logic [IO_VALUE_WIDTH-1:0] read_value,
  input logic [CNT_W-1:0]          item_count,
  input logic                      is_empty,
  input logic                      is_full
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (item_count == '0)))
    else $error("is_empty disagrees with item_count");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_full == (item_count == CNT_FULL)))
    else $error("is_full disagrees with item_count");

  a_fail_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (read_value == '0))
    else $error("failed transaction returned a non-zero value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while one is in flight");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_value) && $stable(status)))
    else $error("result dropped or changed while stalled");

endmodule

bind positional_list_store_unit plsu_checker #(
  .CAPACITY (CAPACITY)
) u_plsu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .read_value (read_value),
  .item_count (item_count),
  .is_empty   (is_empty),
  .is_full    (is_full)
);
